### rtl/assert_macros.svh
// assertion macros shared by the console writer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define TCCW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds during reset
`define TCCW_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/tccw_pkg.sv
// shared types and constants for the text console character writer
package tccw_pkg;

   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;

   localparam int DEF_ROWS = 25;
   localparam int DEF_COLS = 80;

   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_ERASE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic [CHAR_W-1:0]  char_code;
      logic [ROW_W-1:0]   read_row;
      logic [COL_W-1:0]   read_col;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]   cursor_row;
      logic [COL_W-1:0]   cursor_col;
      logic [CHAR_W-1:0]  cell_char;
   } rsp_type;

endpackage

### rtl/tccw_ram.sv
// single write port, single registered read port character store
module tccw_ram #(
   parameter int DEPTH = tccw_pkg::DEF_ROWS * tccw_pkg::DEF_COLS,
   parameter int WIDTH = tccw_pkg::CHAR_W
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/text_console_char_writer_core.sv
// text console character writer: screen store, write position and sweep sequencer
//
// usage notes
//  - req channel (valid/ready) carries one word: operation, char_code, read_row, read_col.
//    put stores a byte (newline moves to the next row), erase blanks the previous cell,
//    clear blanks the screen and homes, read returns one cell.
//  - rsp channel (valid/ready) returns one word per request: the write position after the
//    operation and, for read, the stored byte (zero otherwise or outside the screen).
//  - erase, read and a put with no scroll pending pass from accept through the finishing step
//    to rsp_valid; read data is registered through the single store port pair. a new request
//    is accepted only after the previous one has left the finishing step.
//  - a put with a scroll pending first copies the store up one row, one cell per cycle
//    through the shared address counter, then blanks the bottom row.
//  - clear writes one cell per cycle.
//  - after reset the block blanks the store to zeros, one cell per cycle, with req_ready
//    low; position resets to row 0, column 0.
//  - a stalled rsp holds its word; the next request may be accepted meanwhile but its
//    result waits until the held word is taken.
module text_console_char_writer_core #(
   parameter int ROWS = tccw_pkg::DEF_ROWS,
   parameter int COLS = tccw_pkg::DEF_COLS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tccw_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tccw_pkg::rsp_type rsp_word
);

   import tccw_pkg::*;

`include "assert_macros.svh"

   localparam int RowW  = $clog2(ROWS + 1);
   localparam int ColW  = $clog2(COLS);
   localparam int Cells = ROWS * COLS;
   localparam int AddrW = $clog2(Cells);
   localparam int MoveN = (ROWS - 1) * COLS;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCROLL_MOVE,
      ST_SCROLL_FILL,
      ST_CLEAR,
      ST_EXEC
   } state_type;

   state_type         state_ff;
   logic [RowW-1:0]   row_ff;
   logic [ColW-1:0]   col_ff;
   logic [AddrW-1:0]  sweep_ff;
   logic              mv_pend_ff;
   logic [AddrW-1:0]  mv_addr_ff;
   op_type            op_ff;
   logic [CHAR_W-1:0] ch_ff;
   logic              rd_ok_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_word_ff;

   logic [RowW-1:0]   row_in;
   logic [ColW-1:0]   col_in;
   logic              rsp_valid_in;
   logic [RowW-1:0]   exec_row;
   logic [ColW-1:0]   exec_col;
   logic              exec_wr;
   logic [AddrW-1:0]  exec_addr;
   logic              req_fire;
   logic              out_free;
   logic              rd_in_range;
   logic [AddrW-1:0]  req_addr;

   logic              wr_en;
   logic [AddrW-1:0]  wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic              rd_en;
   logic [AddrW-1:0]  rd_addr;
   logic [CHAR_W-1:0] rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign rsp_valid_in = ((state_ff == ST_EXEC) && out_free) || (rsp_valid_ff && !rsp_ready);

   assign rd_in_range = (int'(req_word.read_row) < ROWS) && (int'(req_word.read_col) < COLS);
   assign req_addr    = AddrW'(req_word.read_row) * AddrW'(COLS) + AddrW'(req_word.read_col);

   // position update and cell write for the finishing step
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      exec_row = row_ff;
      exec_col = col_ff;
      exec_wr  = 1'b0;
      case (op_ff)
         OP_PUT: begin
            if (ch_ff == NEWLINE_CHAR) begin
               row_in = row_ff + RowW'(1);
               col_in = '0;
            end else begin
               exec_wr = (row_ff < RowW'(ROWS));
               if (col_ff == ColW'(COLS - 1)) begin
                  col_in = '0;
                  row_in = row_ff + RowW'(1);
               end else begin
                  col_in = col_ff + ColW'(1);
               end
            end
         end
         OP_ERASE: begin
            if (row_ff == '0) begin
               if (col_ff != '0) begin
                  col_in  = col_ff - ColW'(1);
                  exec_wr = 1'b1;
               end
            end else if (col_ff == '0) begin
               row_in  = row_ff - RowW'(1);
               col_in  = ColW'(COLS - 1);
               exec_wr = 1'b1;
            end else begin
               col_in  = col_ff - ColW'(1);
               exec_wr = (row_ff < RowW'(ROWS));
            end
            exec_row = row_in;
            exec_col = col_in;
         end
         OP_CLEAR: begin
            row_in = '0;
            col_in = '0;
         end
         OP_READ: begin
         end
         default: begin
         end
      endcase
   end

   assign exec_addr = AddrW'(exec_row) * AddrW'(COLS) + AddrW'(exec_col);

   // store port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = BLANK_CHAR;
      rd_en   = 1'b0;
      rd_addr = req_addr;
      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = '0;
         end
         ST_IDLE: begin
            rd_en = req_fire && (req_word.operation == OP_READ);
         end
         ST_SCROLL_MOVE: begin
            wr_en   = mv_pend_ff;
            wr_addr = mv_addr_ff;
            wr_data = rd_data;
            rd_en   = (sweep_ff < AddrW'(MoveN));
            rd_addr = sweep_ff + AddrW'(COLS);
         end
         ST_SCROLL_FILL, ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_EXEC: begin
            wr_en   = out_free && exec_wr;
            wr_addr = exec_addr;
            wr_data = (op_ff == OP_PUT) ? ch_ff : BLANK_CHAR;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         sweep_ff     <= '0;
         mv_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_INIT: begin
               sweep_ff <= sweep_ff + AddrW'(1);
               if (sweep_ff == AddrW'(Cells - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               sweep_ff   <= '0;
               mv_pend_ff <= 1'b0;
               if (req_fire) begin
                  op_ff    <= req_word.operation;
                  ch_ff    <= req_word.char_code;
                  rd_ok_ff <= rd_in_range;
                  case (req_word.operation)
                     OP_PUT: begin
                        if (row_ff >= RowW'(ROWS)) begin
                           state_ff <= ST_SCROLL_MOVE;
                        end else begin
                           state_ff <= ST_EXEC;
                        end
                     end
                     OP_CLEAR: state_ff <= ST_CLEAR;
                     default:  state_ff <= ST_EXEC;
                  endcase
               end
            end
            ST_SCROLL_MOVE: begin
               if (sweep_ff < AddrW'(MoveN)) begin
                  mv_pend_ff <= 1'b1;
                  mv_addr_ff <= sweep_ff;
                  sweep_ff   <= sweep_ff + AddrW'(1);
               end else begin
                  mv_pend_ff <= 1'b0;
                  state_ff   <= ST_SCROLL_FILL;
               end
            end
            ST_SCROLL_FILL: begin
               sweep_ff <= sweep_ff + AddrW'(1);
               if (sweep_ff == AddrW'(Cells - 1)) begin
                  row_ff   <= RowW'(ROWS - 1);
                  col_ff   <= '0;
                  state_ff <= ST_EXEC;
               end
            end
            ST_CLEAR: begin
               sweep_ff <= sweep_ff + AddrW'(1);
               if (sweep_ff == AddrW'(Cells - 1)) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (out_free) begin
                  row_ff                 <= row_in;
                  col_ff                 <= col_in;
                  rsp_word_ff.cursor_row <= ROW_W'(row_in);
                  rsp_word_ff.cursor_col <= COL_W'(col_in);
                  rsp_word_ff.cell_char  <= ((op_ff == OP_READ) && rd_ok_ff) ? rd_data : '0;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   tccw_ram #(
      .DEPTH (Cells),
      .WIDTH (CHAR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // write position stays on the screen or on the pending scroll row
   `TCCW_ASSERT(a_row_range, row_ff <= RowW'(ROWS), "write row beyond scroll row")
   `TCCW_ASSERT(a_col_range, col_ff <= ColW'(COLS - 1), "write column beyond last column")
   // a word only appears from the finishing step
   `TCCW_ASSERT(a_rsp_from_exec, $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC),
      "response raised outside finishing step")
   // a copied cell is never left unwritten when the move phase ends
   `TCCW_ASSERT_ALWAYS(a_move_drained, mv_pend_ff |-> (state_ff == ST_SCROLL_MOVE),
      "scroll copy write pending outside move phase")

endmodule
